/* sv/lr_shift_reduce_parser_macros.svh */
// Assertion macros used by the parse engine datapath.
`ifndef LR_SHIFT_REDUCE_PARSER_MACROS_SVH
`define LR_SHIFT_REDUCE_PARSER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LRP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define LRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/lrp_pkg.sv */
// Types and constants of the LR parse engine.
`timescale 1ns / 1ps
package lrp_pkg;

    typedef enum logic [1:0] {
        REQ_FEED   = 2'd0,
        REQ_ACTION = 2'd1,
        REQ_GOTO   = 2'd2,
        REQ_LENGTH = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ACT_ERROR  = 2'd0,
        ACT_SHIFT  = 2'd1,
        ACT_REDUCE = 2'd2,
        ACT_ACCEPT = 2'd3
    } act_t;

    typedef enum logic [2:0] {
        EV_REDUCED  = 3'd0,
        EV_SHIFTED  = 3'd1,
        EV_ACCEPTED = 3'd2,
        EV_SYNTAX   = 3'd3,
        EV_STACK    = 3'd4,
        EV_CHAIN    = 3'd5,
        EV_WRITTEN  = 3'd6
    } ev_t;

    typedef enum logic {
        CFG_TOKEN_KINDS      = 1'b0,
        CFG_PRODUCTION_KINDS = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_WRITE,
        OP_FEED,
        OP_SHIFT,
        OP_CLEAR,
        OP_LEN,
        OP_POP,
        OP_GOTO
    } op_t;

    localparam logic [5:0] CHAIN_LIMIT = 6'd63;
    localparam logic [6:0] KINDS_RESET = 7'd64;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [5:0]  token_kind;
        logic [13:0] table_address;
        logic [1:0]  action_kind;
        logic [7:0]  entry_value;
    } request_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [5:0] production;
        logic [7:0] top_state;
        logic       last;
    } result_t;

    typedef struct packed {
        op_t op;
        ev_t ev;
    } cmd_t;

    typedef struct packed {
        act_t act_kind;
        logic depth_full;
        logic chain_max;
        logic arg_big;
        logic len_bad;
    } status_t;

endpackage

/* sv/lr_shift_reduce_parser.sv */
// Top level of the table-driven LR parse engine.
// channel   | handshake                 | word
// request   | start, accepted if !busy  | request (req_type, token_kind, ...)
// result    | result_valid, one cycle   | result (event_res, production, ...)
// config    | cfg_valid / cfg_ready     | cfg_index, cfg_data
// A table write answers in the cycle after it is taken; busy stays low.
// A token looks up the action table and ends in a shift, accept or error result;
// each reduction reads the length table, the state stack and the goto table in turn,
// each through a registered memory read, then looks up the action table again.
// Reset leaves the stack at depth one holding state 0; tables are not cleared.
// Results are not held: each one shows for exactly one cycle.
`timescale 1ns / 1ps
module lr_shift_reduce_parser #(
    parameter int MAX_STATES      = 256,
    parameter int MAX_TOKENS      = 64,
    parameter int MAX_PRODUCTIONS = 64,
    parameter int STACK_DEPTH     = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lrp_pkg::request_t request,
    output logic              result_valid,
    output lrp_pkg::result_t  result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [6:0]        cfg_data
);

    lrp_pkg::cmd_t    cmd;
    lrp_pkg::status_t status;

    assign cfg_ready = 1'b1;

    lrp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (request.req_type),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    lrp_dpath #(
        .MAX_STATES      (MAX_STATES),
        .MAX_TOKENS      (MAX_TOKENS),
        .MAX_PRODUCTIONS (MAX_PRODUCTIONS),
        .STACK_DEPTH     (STACK_DEPTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .cmd          (cmd),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

/* sv/lrp_ctrl.sv */
// Sequencer of the parse engine: steps each feed request through the table reads and issues table writes.
`timescale 1ns / 1ps
module lrp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       req_type,
    input  lrp_pkg::status_t status,
    output lrp_pkg::cmd_t    cmd,
    output logic             busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACT,
        S_LEN,
        S_STK,
        S_GOTO
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op = lrp_pkg::OP_NONE;
        cmd.ev = lrp_pkg::EV_SYNTAX;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req_type == lrp_pkg::REQ_FEED)
                    begin
                        cmd.op = lrp_pkg::OP_FEED;
                        state_next = S_ACT;
                    end
                    else
                    begin
                        cmd.op = lrp_pkg::OP_WRITE;
                    end
                end
            end
            S_ACT:
            begin
                state_next = S_IDLE;
                unique case (status.act_kind)
                    lrp_pkg::ACT_SHIFT:
                    begin
                        if (status.depth_full)
                        begin
                            cmd.op = lrp_pkg::OP_CLEAR;
                            cmd.ev = lrp_pkg::EV_STACK;
                        end
                        else
                        begin
                            cmd.op = lrp_pkg::OP_SHIFT;
                        end
                    end
                    lrp_pkg::ACT_REDUCE:
                    begin
                        if (status.chain_max)
                        begin
                            cmd.op = lrp_pkg::OP_CLEAR;
                            cmd.ev = lrp_pkg::EV_CHAIN;
                        end
                        else if (status.arg_big)
                        begin
                            cmd.op = lrp_pkg::OP_CLEAR;
                            cmd.ev = lrp_pkg::EV_SYNTAX;
                        end
                        else
                        begin
                            cmd.op = lrp_pkg::OP_LEN;
                            state_next = S_LEN;
                        end
                    end
                    lrp_pkg::ACT_ACCEPT:
                    begin
                        cmd.op = lrp_pkg::OP_CLEAR;
                        cmd.ev = lrp_pkg::EV_ACCEPTED;
                    end
                    default:
                    begin
                        cmd.op = lrp_pkg::OP_CLEAR;
                        cmd.ev = lrp_pkg::EV_SYNTAX;
                    end
                endcase
            end
            S_LEN:
            begin
                if (status.len_bad)
                begin
                    cmd.op = lrp_pkg::OP_CLEAR;
                    cmd.ev = lrp_pkg::EV_STACK;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op = lrp_pkg::OP_POP;
                    state_next = S_STK;
                end
            end
            S_STK:
            begin
                cmd.op = lrp_pkg::OP_NONE;
                state_next = S_GOTO;
            end
            S_GOTO:
            begin
                // push goto state, report reduction, look up action again
                cmd.op = lrp_pkg::OP_GOTO;
                state_next = S_ACT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

/* sv/lrp_dpath.sv */
// Datapath of the parse engine: tables, state stack, config and result register.
`timescale 1ns / 1ps
`include "lr_shift_reduce_parser_macros.svh"
module lrp_dpath #(
    parameter int MAX_STATES      = 256,
    parameter int MAX_TOKENS      = 64,
    parameter int MAX_PRODUCTIONS = 64,
    parameter int STACK_DEPTH     = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lrp_pkg::request_t request,
    input  lrp_pkg::cmd_t     cmd,
    output lrp_pkg::status_t  status,
    input  logic              cfg_valid,
    input  logic              cfg_index,
    input  logic [6:0]        cfg_data,
    output logic              result_valid,
    output lrp_pkg::result_t  result
);

    localparam int ACT_SIZE  = MAX_STATES * MAX_TOKENS;
    localparam int GOTO_SIZE = MAX_STATES * MAX_PRODUCTIONS;
    localparam int AW = $clog2(ACT_SIZE);
    localparam int GW = $clog2(GOTO_SIZE);
    localparam int AX = (AW > 16) ? AW + 1 : 17;
    localparam int GX = (GW > 16) ? GW + 1 : 17;
    localparam int PW = (MAX_PRODUCTIONS > 1) ? $clog2(MAX_PRODUCTIONS) : 1;
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int DX = (DW > 4) ? DW : 4;

    logic [9:0] act_mem [ACT_SIZE];
    logic [7:0] goto_mem [GOTO_SIZE];
    logic [3:0] len_mem [MAX_PRODUCTIONS];
    logic [7:0] stk_mem [STACK_DEPTH];

    logic [6:0]    tk_reg, pk_reg;
    logic [5:0]    tok_reg;
    logic [7:0]    prod_reg;
    logic [5:0]    chain_reg;
    logic [DW-1:0] depth_reg;
    logic [7:0]    top_reg;
    logic [9:0]    act_q;
    logic          act_oob_reg;
    logic [3:0]    len_q;
    logic [7:0]    stk_q;
    logic          stk_zero_reg;
    logic [7:0]    goto_q;
    logic          goto_oob_reg;
    logic          strobe_reg;
    lrp_pkg::result_t res_reg;

    logic [7:0]    act_top, goto_next, stk_top;
    logic [5:0]    act_tok;
    logic [AX-1:0] act_idx, act_waddr;
    logic [GX-1:0] goto_idx, goto_waddr;
    logic [DX-1:0] len_w, dep_w, pop_w;
    logic [DW-1:0] pop_depth;
    logic [SW-1:0] stk_raddr;
    logic          act_rd;

    assign goto_next = goto_oob_reg ? 8'd0 : goto_q;
    assign stk_top   = stk_zero_reg ? 8'd0 : stk_q;

    // action lookup takes the request token and top state on entry, the saved token and goto state on a chain
    assign act_top = (cmd.op == lrp_pkg::OP_GOTO) ? goto_next : top_reg;
    assign act_tok = (cmd.op == lrp_pkg::OP_GOTO) ? tok_reg : request.token_kind;
    assign act_rd  = (cmd.op == lrp_pkg::OP_FEED) || (cmd.op == lrp_pkg::OP_GOTO);
    assign act_idx = AX'(tk_reg) * AX'(act_top) + AX'(act_tok);
    assign goto_idx = GX'(pk_reg) * GX'(stk_top) + GX'(prod_reg);
    assign act_waddr  = AX'(request.table_address);
    assign goto_waddr = GX'(request.table_address);

    assign len_w = DX'(len_q);
    assign dep_w = DX'(depth_reg);
    assign pop_w = dep_w - len_w;
    assign pop_depth = DW'(pop_w);
    assign stk_raddr = SW'(pop_depth - DW'(1));

    always_comb
    begin
        status.act_kind   = act_oob_reg ? lrp_pkg::ACT_ERROR : lrp_pkg::act_t'(act_q[9:8]);
        status.depth_full = (depth_reg >= DW'(STACK_DEPTH));
        status.chain_max  = (chain_reg == lrp_pkg::CHAIN_LIMIT);
        status.arg_big    = ({1'b0, act_q[7:0]} >= 9'(MAX_PRODUCTIONS));
        status.len_bad    = (len_w >= dep_w) || (pop_w >= DX'(STACK_DEPTH));
    end

    // table memories
    always_ff @(posedge clk)
    begin
        if (cmd.op == lrp_pkg::OP_WRITE)
        begin
            case (request.req_type)
                lrp_pkg::REQ_ACTION:
                    if (act_waddr < AX'(ACT_SIZE))
                        act_mem[act_waddr[AW-1:0]] <= {request.action_kind,
                                                       request.entry_value};
                lrp_pkg::REQ_GOTO:
                    if (goto_waddr < GX'(GOTO_SIZE))
                        goto_mem[goto_waddr[GW-1:0]] <= request.entry_value;
                lrp_pkg::REQ_LENGTH:
                    if (15'(request.table_address) < 15'(MAX_PRODUCTIONS))
                        len_mem[request.table_address[PW-1:0]] <= request.entry_value[3:0];
                default:
                begin
                end
            endcase
        end
        if (act_rd)
        begin
            act_q <= act_mem[act_idx[AW-1:0]];
            act_oob_reg <= (act_idx >= AX'(ACT_SIZE));
        end
        if (cmd.op == lrp_pkg::OP_LEN)
            len_q <= len_mem[act_q[PW-1:0]];
        if (cmd.op == lrp_pkg::OP_NONE)
        begin
            goto_q <= goto_mem[goto_idx[GW-1:0]];
            goto_oob_reg <= (goto_idx >= GX'(GOTO_SIZE));
        end
    end

    // state stack; entry 0 always reads as the start state
    always_ff @(posedge clk)
    begin
        if (cmd.op == lrp_pkg::OP_SHIFT)
            stk_mem[depth_reg[SW-1:0]] <= act_q[7:0];
        else if (cmd.op == lrp_pkg::OP_GOTO)
            stk_mem[depth_reg[SW-1:0]] <= goto_next;
        if (cmd.op == lrp_pkg::OP_POP)
        begin
            stk_q <= stk_mem[stk_raddr];
            stk_zero_reg <= (pop_depth == DW'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == lrp_pkg::OP_FEED)
            tok_reg <= request.token_kind;
        if (cmd.op == lrp_pkg::OP_LEN)
            prod_reg <= act_q[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tk_reg     <= lrp_pkg::KINDS_RESET;
            pk_reg     <= lrp_pkg::KINDS_RESET;
            depth_reg  <= DW'(1);
            top_reg    <= 8'd0;
            chain_reg  <= 6'd0;
            strobe_reg <= 1'b0;
            res_reg    <= '0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            if (cfg_valid)
            begin
                unique case (lrp_pkg::cfg_idx_t'(cfg_index))
                    lrp_pkg::CFG_TOKEN_KINDS:      tk_reg <= cfg_data;
                    lrp_pkg::CFG_PRODUCTION_KINDS: pk_reg <= cfg_data;
                    default:                       tk_reg <= tk_reg;
                endcase
            end
            unique case (cmd.op)
                lrp_pkg::OP_WRITE:
                begin
                    strobe_reg <= 1'b1;
                    res_reg <= '{event_res: lrp_pkg::EV_WRITTEN, production: 6'd0,
                                 top_state: top_reg, last: 1'b1};
                end
                lrp_pkg::OP_FEED:
                begin
                    chain_reg <= 6'd0;
                end
                lrp_pkg::OP_SHIFT:
                begin
                    depth_reg <= depth_reg + DW'(1);
                    top_reg <= act_q[7:0];
                    strobe_reg <= 1'b1;
                    res_reg <= '{event_res: lrp_pkg::EV_SHIFTED, production: 6'd0,
                                 top_state: act_q[7:0], last: 1'b1};
                end
                lrp_pkg::OP_CLEAR:
                begin
                    depth_reg <= DW'(1);
                    top_reg <= 8'd0;
                    strobe_reg <= 1'b1;
                    res_reg <= '{event_res: cmd.ev, production: 6'd0,
                                 top_state: 8'd0, last: 1'b1};
                end
                lrp_pkg::OP_POP:
                begin
                    depth_reg <= pop_depth;
                end
                lrp_pkg::OP_GOTO:
                begin
                    depth_reg <= depth_reg + DW'(1);
                    top_reg <= goto_next;
                    chain_reg <= chain_reg + 6'd1;
                    strobe_reg <= 1'b1;
                    res_reg <= '{event_res: lrp_pkg::EV_REDUCED, production: prod_reg[5:0],
                                 top_state: goto_next, last: 1'b0};
                end
                default:
                begin
                end
            endcase
        end
    end

    assign result_valid = strobe_reg;
    assign result = res_reg;

    `LRP_ASSERT_NOW(a_depth_range, 1'b1, (depth_reg != '0) && (depth_reg <= DW'(STACK_DEPTH)), "stack depth out of range")
    `LRP_ASSERT_NOW(a_reduce_not_last, strobe_reg && (res_reg.event_res == lrp_pkg::EV_REDUCED), !res_reg.last, "reduction marked last")
    `LRP_ASSERT_NEXT(a_clear_resets, cmd.op == lrp_pkg::OP_CLEAR, (depth_reg == DW'(1)) && (top_reg == 8'd0), "stack not reset after accept or error")
    `LRP_ASSERT_NEXT(a_shift_push, (cmd.op == lrp_pkg::OP_SHIFT) && (depth_reg < DW'(STACK_DEPTH)), (depth_reg == $past(depth_reg) + DW'(1)), "shift did not push")

endmodule
